// ===== src/psq_pkg.sv =====
// Shared types and codes for the processor-sharing job table.
`timescale 1ns / 1ps
package psq_pkg;

    // Operation selector carried in the request
    localparam logic [1:0] FUNC_ARRIVE   = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;
    localparam logic [1:0] FUNC_COMPLETE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Slot scan modes
    localparam logic [1:0] SCAN_FREE = 2'd0;
    localparam logic [1:0] SCAN_MIN  = 2'd1;
    localparam logic [1:0] SCAN_DED  = 2'd2;

    localparam int WORK_W = 32;

    // Controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       scan_start;
        logic [1:0] scan_mode;
        logic       remove;
        logic       mul_go;
        logic       div_start;
        logic       out_load;
        logic [1:0] out_status;
    } psq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       count_zero;
        logic       count_full;
        logic       scan_done;
        logic       div_done;
        logic       out_free;
    } psq_sts_t;

endpackage

// ===== src/psq_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module psq_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    // One restoring step on the running remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[63]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = 32'(trial - {1'b0, dsr_reg});
            dvd_next = {dvd_reg[62:0], 1'b1};
        end
        else
        begin
            rem_next = trial[31:0];
            dvd_next = {dvd_reg[62:0], 1'b0};
        end
    end

    // Control: count 64 steps, pulse done after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and shifting quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= 32'd0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule

// ===== src/psq_dp.sv =====
// Datapath: job slots, slot scanner, multiplier, divider and result register.
`timescale 1ns / 1ps
module psq_dp #(
    parameter int MAX_JOBS = 16,
    parameter int ID_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  psq_pkg::psq_cmd_t cmd,
    output psq_pkg::psq_sts_t sts,
    input  logic [1:0]       in_func,
    input  logic [15:0]      in_job_id,
    input  logic [31:0]      in_amount,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_next_id,
    output logic [31:0]      out_finish_time,
    output logic [1:0]       out_status
);
    import psq_pkg::*;

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_JOBS - 1);

    // Slot storage
    logic [WORK_W-1:0]  work_mem [MAX_JOBS];
    logic [ID_BITS-1:0] id_mem   [MAX_JOBS];
    logic [MAX_JOBS-1:0] valid_reg;
    logic [CW-1:0]      count_reg;

    logic [31:0]        rate_reg;
    logic [1:0]         func_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        amount_reg;

    // Scanner
    logic               issue_reg;
    logic [IW-1:0]      idx_reg;
    logic               p_vld_reg;
    logic [IW-1:0]      p_idx_reg;
    logic [WORK_W-1:0]  rd_work_reg;
    logic [ID_BITS-1:0] rd_id_reg;
    logic [1:0]         mode_reg;
    logic               found_reg;

    logic               best_any_reg;
    logic [IW-1:0]      best_idx_reg;
    logic [WORK_W-1:0]  best_work_reg;
    logic [ID_BITS-1:0] best_id_reg;

    logic [32:0]        ded_reg;
    logic [31:0]        fin_reg;
    logic [63:0]        prod_reg;

    logic               out_valid_reg;
    logic [15:0]        out_id_reg;
    logic [31:0]        out_fin_reg;
    logic [1:0]         out_st_reg;

    logic               arr_write;
    logic               ded_write;
    logic [WORK_W-1:0]  ded_work;
    logic               take_best;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        div_dvd;
    logic [31:0]        div_dsr;
    logic [63:0]        quot;
    logic               div_done;

    // Slot actions of the processing stage
    always_comb
    begin
        arr_write = p_vld_reg && (mode_reg == SCAN_FREE) && !valid_reg[p_idx_reg] && !found_reg;
        ded_write = p_vld_reg && (mode_reg == SCAN_DED) && valid_reg[p_idx_reg];
        take_best = p_vld_reg && (mode_reg == SCAN_MIN) && valid_reg[p_idx_reg]
                    && (!best_any_reg || (rd_work_reg < best_work_reg));
        if ({1'b0, rd_work_reg} <= ded_reg)
            ded_work = '0;
        else
            ded_work = rd_work_reg - ded_reg[31:0];
    end

    // Multiplier operands and divider operands by operation
    always_comb
    begin
        if (func_reg == FUNC_ADVANCE)
        begin
            mul_a   = amount_reg;
            mul_b   = rate_reg;
            div_dvd = {16'd0, prod_reg[63:16]};
            div_dsr = 32'(count_reg);
        end
        else
        begin
            mul_a   = best_work_reg;
            mul_b   = 32'(count_reg);
            div_dvd = {prod_reg[47:0], 16'd0};
            div_dsr = rate_reg;
        end
    end

    psq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (quot),
        .done     (div_done)
    );

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (arr_write)
        begin
            work_mem[p_idx_reg] <= amount_reg;
            id_mem[p_idx_reg]   <= id_reg;
        end
        else if (ded_write)
        begin
            work_mem[p_idx_reg] <= ded_work;
        end
        rd_work_reg <= work_mem[idx_reg];
        rd_id_reg   <= id_mem[idx_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= in_func;
            id_reg     <= ID_BITS'(in_job_id);
            amount_reg <= in_amount;
        end
        if (cmd.scan_start)
            mode_reg <= cmd.scan_mode;
        if (take_best)
        begin
            best_idx_reg  <= p_idx_reg;
            best_work_reg <= rd_work_reg;
            best_id_reg   <= rd_id_reg;
        end
        if (cmd.mul_go)
            prod_reg <= mul_a * mul_b;
        if (cmd.remove)
            ded_reg <= {1'b0, best_work_reg};
        else if (div_done && func_reg == FUNC_ADVANCE)
            ded_reg <= (quot[63:32] != 32'd0) ? 33'h1_0000_0000 : {1'b0, quot[31:0]};
        if (div_done && func_reg == FUNC_QUERY)
            fin_reg <= (quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : quot[31:0];
        if (cmd.out_load)
        begin
            out_st_reg  <= cmd.out_status;
            out_id_reg  <= (cmd.out_status == ST_OK && func_reg[1]) ? 16'(best_id_reg) : 16'd0;
            out_fin_reg <= (cmd.out_status == ST_OK && func_reg == FUNC_QUERY) ? fin_reg : 32'd0;
        end
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= 32'd65536;
            valid_reg     <= '0;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            idx_reg       <= '0;
            p_vld_reg     <= 1'b0;
            p_idx_reg     <= '0;
            found_reg     <= 1'b0;
            best_any_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rate_reg <= cfg_data;

            // advance the read address across all slots
            if (cmd.scan_start)
            begin
                issue_reg    <= 1'b1;
                idx_reg      <= '0;
                found_reg    <= 1'b0;
                best_any_reg <= 1'b0;
            end
            else if (issue_reg)
            begin
                if (idx_reg == LAST_IDX)
                    issue_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            p_vld_reg <= issue_reg;
            p_idx_reg <= idx_reg;

            if (take_best)
                best_any_reg <= 1'b1;
            if (arr_write)
            begin
                valid_reg[p_idx_reg] <= 1'b1;
                count_reg            <= count_reg + 1'b1;
                found_reg            <= 1'b1;
            end
            if (cmd.remove)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                count_reg               <= count_reg - 1'b1;
            end

            // hold the result until the receiver takes it
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.func       = func_reg;
        sts.count_zero = (count_reg == '0);
        sts.count_full = (count_reg == CW'(MAX_JOBS));
        sts.scan_done  = p_vld_reg && (p_idx_reg == LAST_IDX);
        sts.div_done   = div_done;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_next_id     = out_id_reg;
    assign out_finish_time = out_fin_reg;
    assign out_status      = out_st_reg;
endmodule

// ===== src/psq_ctrl.sv =====
// Controller: sequences each request through scan, multiply and divide steps.
`timescale 1ns / 1ps
module psq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psq_pkg::psq_sts_t sts,
    output psq_pkg::psq_cmd_t cmd
);
    import psq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_REMOVE = 4'd3;
    localparam logic [3:0] S_DED    = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DIVGO  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.out_status = st_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next = ST_OK;
                if (sts.func == FUNC_ARRIVE)
                begin
                    if (sts.count_full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_FREE;
                        state_next     = S_SCAN;
                    end
                end
                else if (sts.count_zero)
                begin
                    st_next    = ST_EMPTY;
                    state_next = S_OUT;
                end
                else if (sts.func == FUNC_ADVANCE)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_MIN;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.func == FUNC_ARRIVE)
                        state_next = S_OUT;
                    else if (sts.func == FUNC_QUERY)
                        state_next = S_MUL;
                    else
                        state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                // drop the least job and deduct its work from the rest
                cmd.remove     = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_DED;
                state_next     = S_DED;
            end
            S_DED:
            begin
                if (sts.scan_done)
                    state_next = S_OUT;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.func == FUNC_ADVANCE)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_DED;
                        state_next     = S_DED;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end
endmodule

// ===== src/processor_sharing_queue.sv =====
// Top level of the processor-sharing job table.
//
// Requests enter on s_tvalid/s_tready: s_tuser is the operation (arrival,
// advance time, query next, complete next), s_tdata carries the job id and
// the Q16.16 amount. Each request gives exactly one result on m_tvalid/
// m_tready: m_tdata holds next id and finish time, m_tuser the status.
// The service rate comes in on cfg_valid/cfg_data. The user must write it
// only while the block is idle; the block itself does not enforce this.
// One request is in work at a time. Apart from a non-arrival request on an
// empty table and an arrival on a full table, which go straight to the
// result, each request runs a slot scan (one slot per cycle through the slot
// memory); advance and query also run the 64-step divider.
// A finished result waits in an output register; while the receiver stalls,
// the next request is still taken and runs up to its own result.
// Reset empties the table and sets the rate to 1.0; no clearing pass is run.
`timescale 1ns / 1ps
module processor_sharing_queue #(
    parameter int MAX_JOBS = 16,
    parameter int ID_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // job_id[15:0], amount[47:16]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // next_id[15:0], finish_time[47:16]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import psq_pkg::*;

    psq_cmd_t    cmd;
    psq_sts_t    sts;
    logic [15:0] next_id;
    logic [31:0] finish_time;

    assign cfg_ready = 1'b1;

    psq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psq_dp #(
        .MAX_JOBS (MAX_JOBS),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_tuser),
        .in_job_id       (s_tdata[15:0]),
        .in_amount       (s_tdata[47:16]),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_next_id     (next_id),
        .out_finish_time (finish_time),
        .out_status      (m_tuser)
    );

    assign m_tdata = {finish_time, next_id};

    // One request at a time: no new request right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in work");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten");

    // Divider never finishes in the cycle after it starts
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider done too early");
endmodule
